### rtl/core/rhd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_pkg: shared types and constants for the remote HID report decoder
// Report ids, payload lengths, button table and the front-to-back record.
// ----------------------------------------------------------------------------
package rhd_pkg;

  localparam int unsigned DECODED_PAYLOAD_BYTES = 20;
  localparam int unsigned NumButtons            = 39;
  localparam int unsigned StoreAw               = $clog2(DECODED_PAYLOAD_BYTES);
  localparam int unsigned OutDataW              = 208;

  localparam logic [7:0] IdDecoded = 8'hFD;
  localparam logic [7:0] IdLongA   = 8'hF9;
  localparam logic [7:0] IdLongB   = 8'h01;

  localparam logic [4:0] LenDecoded = 5'(DECODED_PAYLOAD_BYTES);
  localparam logic [4:0] LenLong    = 5'd29;
  localparam logic [4:0] LenShort   = 5'd15;
  localparam logic [5:0] IdxUnknown = 6'(NumButtons);

  localparam logic [15:0] ButtonTable [NumButtons] = '{
    16'h0000, 16'h8000, 16'h8099, 16'h8010, 16'h8011, 16'h8012, 16'h8013, 16'h8014,
    16'h8015, 16'h8016, 16'h8017, 16'h8018, 16'h8019, 16'h8044, 16'h8053, 16'h8045,
    16'h8002, 16'h8003, 16'h8009, 16'h808B, 16'h807C, 16'h8043, 16'h8028, 16'h80AB,
    16'h805D, 16'h800B, 16'h8098, 16'h8001, 16'h8072, 16'h8071, 16'h8063, 16'h8061,
    16'h8081, 16'h80B0, 16'h80BA, 16'h8040, 16'h8041, 16'h8006, 16'h8007
  };

  // one finished report, handed from framing to decode
  typedef struct packed {
    logic [7:0]  id;
    logic [4:0]  len;
    logic        decode;
    logic [15:0] code;
    logic [7:0]  delta;
    logic [15:0] counter;
    logic [15:0] fixed_word;
    logic [47:0] poi;
    logic [47:0] accel;
  } rhd_rec_t;

  function automatic logic [4:0] expected_len(input logic [7:0] id);
    logic [4:0] len;
    if (id == IdDecoded) begin
      len = LenDecoded;
    end else if (id == IdLongA || id == IdLongB) begin
      len = LenLong;
    end else begin
      len = LenShort;
    end
    return len;
  endfunction

  // first matching entry wins
  function automatic logic [5:0] button_lookup(input logic [15:0] code);
    logic [5:0] idx;
    idx = IdxUnknown;
    for (int k = NumButtons - 1; k >= 0; k--) begin
      if (ButtonTable[k] == code) begin
        idx = 6'(k);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/core/rhd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_front: report framing
// Takes stream bytes, tracks id and length, keeps the first payload bytes
// and pushes one record per finished or flushed report.
// ----------------------------------------------------------------------------
module rhd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] stream_byte
  input  logic                s_axis_tlast,   // stream_end
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output rhd_pkg::rhd_rec_t   push_rec_o
);
  import rhd_pkg::*;

  logic                in_report_q, in_report_d;
  logic [7:0]          id_q, id_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [7:0]          store_q [DECODED_PAYLOAD_BYTES];
  logic                accept;
  logic [4:0]          cnt_inc;

  assign s_axis_tready = push_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cnt_inc       = cnt_q + 5'd1;

  always_comb begin
    in_report_d  = in_report_q;
    id_d         = id_q;
    cnt_d        = cnt_q;
    push_valid_o = 1'b0;

    push_rec_o.id         = id_q;
    push_rec_o.len        = cnt_q;
    push_rec_o.decode     = 1'b0;
    push_rec_o.code       = {store_q[17], store_q[18]};
    push_rec_o.delta      = s_axis_tdata;
    push_rec_o.counter    = {store_q[2], store_q[1]};
    push_rec_o.fixed_word = {store_q[4], store_q[3]};
    push_rec_o.poi        = {store_q[9], store_q[10], store_q[7], store_q[8],
                             store_q[5], store_q[6]};
    push_rec_o.accel      = {store_q[15], store_q[16], store_q[13], store_q[14],
                             store_q[11], store_q[12]};

    if (accept) begin
      if (s_axis_tlast) begin
        if (in_report_q) begin
          push_valid_o = 1'b1;
          in_report_d  = 1'b0;
          cnt_d        = '0;
        end
      end else if (!in_report_q) begin
        id_d        = s_axis_tdata;
        cnt_d       = '0;
        in_report_d = 1'b1;
      end else if (cnt_inc >= expected_len(id_q)) begin
        push_valid_o      = 1'b1;
        push_rec_o.len    = cnt_inc;
        push_rec_o.decode = (id_q == IdDecoded);
        in_report_d       = 1'b0;
        cnt_d             = '0;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_report_q <= 1'b0;
      id_q        <= '0;
      cnt_q       <= '0;
    end else begin
      in_report_q <= in_report_d;
      id_q        <= id_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !s_axis_tlast && in_report_q &&
        cnt_q < 5'(DECODED_PAYLOAD_BYTES)) begin
      store_q[cnt_q[StoreAw-1:0]] <= s_axis_tdata;
    end
  end

endmodule

### rtl/core/rhd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_queue: two-entry report queue
// Decouples framing from decode so either side may stall on its own.
// ----------------------------------------------------------------------------
module rhd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  rhd_pkg::rhd_rec_t push_rec_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output rhd_pkg::rhd_rec_t pop_rec_o
);
  import rhd_pkg::*;

  rhd_rec_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_rec_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_rec_i;
  end

endmodule

### rtl/core/rhd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_back: report decode and output register
// Looks up the button code, advances the wheel position and holds the
// result until it is taken.
// ----------------------------------------------------------------------------
module rhd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  rhd_pkg::rhd_rec_t      pop_rec_i,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [rhd_pkg::OutDataW-1:0] m_axis_tdata
);
  import rhd_pkg::*;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [31:0]         wheel_q, wheel_d;
  logic                take;
  logic                dec;

  assign pop_ready_o   = !out_valid_q || m_axis_tready;
  assign take          = pop_valid_i && pop_ready_o;
  assign dec           = pop_rec_i.decode;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    wheel_d = wheel_q;
    if (dec) wheel_d = wheel_q + {{24{pop_rec_i.delta[7]}}, pop_rec_i.delta};
    out_data_d = {5'd0,
                  dec ? pop_rec_i.accel      : 48'd0,
                  dec ? pop_rec_i.poi        : 48'd0,
                  dec ? pop_rec_i.fixed_word : 16'd0,
                  dec ? pop_rec_i.counter    : 16'd0,
                  wheel_d,
                  dec ? pop_rec_i.delta      : 8'd0,
                  dec ? button_lookup(pop_rec_i.code) : 6'd0,
                  dec ? pop_rec_i.code       : 16'd0,
                  pop_rec_i.len,
                  pop_rec_i.id};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      wheel_q     <= '0;
    end else begin
      if (pop_ready_o) out_valid_q <= pop_valid_i;
      if (take)        wheel_q     <= wheel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_data_q <= out_data_d;
  end

endmodule

### rtl/core/remote_hid_report_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_hid_report_decoder: HID report framing and decode
// Frames a raw byte stream into reports and emits one decoded result per
// finished or flushed report.
//
// channel  dir  width  contents
// s_axis   in   8+1    tdata: stream_byte; tlast: stream_end
// m_axis   out  208    tdata: report fields, see port comment
//
// One byte is taken per cycle while s_axis_tready is high; framing, queue and
// decode each move one request per cycle when not stalled, so the sustained
// rate is one byte a cycle. Results pass the queue, then the output register.
// s_axis_tready drops only while the two-entry report queue is full.
// Reset clears framing state, the queue and the wheel position to zero.
// ----------------------------------------------------------------------------
module remote_hid_report_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] stream_byte
  input  logic                          s_axis_tlast,  // stream_end
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] hdr_id, [12:8] payload_length, [28:13] button_code,
  // [34:29] button_index, [42:35] wheel_delta, [74:43] wheel_total,
  // [90:75] frame_counter, [106:91] fixed_word, [154:107] poi_words,
  // [202:155] accel_words, [207:203] zero
  output logic [rhd_pkg::OutDataW-1:0]  m_axis_tdata
);
  import rhd_pkg::*;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  rhd_rec_t push_rec, pop_rec;

  rhd_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_rec_o   (push_rec)
  );

  rhd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_rec_i   (push_rec),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_rec_o    (pop_rec)
  );

  rhd_back u_back (
    .clk_i,
    .rst_ni,
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_rec_i    (pop_rec),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

endmodule

### rtl/core/rhd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_checker: port-level checks for the report decoder
// Watches the output stream for held results and consistent report fields.
// ----------------------------------------------------------------------------
module rhd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rhd_pkg::OutDataW-1:0]  m_axis_tdata
);
  import rhd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[12:8] <= LenLong)
    else $error("payload length out of range");

  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[34:29] <= IdxUnknown)
    else $error("button index out of range");

  a_undec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7:0] != IdDecoded
      |-> m_axis_tdata[42:13] == 30'd0 && m_axis_tdata[202:75] == 128'd0)
    else $error("undecoded report carries decoded fields");

endmodule

bind remote_hid_report_decoder rhd_checker u_rhd_checker (
  .clk_i,
  .rst_ni,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata
);

### tb/remote_hid_report_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_hid_report_decoder_tb: self-checking bench for the HID report decoder
// Feeds framed and broken report streams, predicts each result with a local
// framing and decode model, and checks every output field. Both sides idle
// in random bursts; one long output hold forces the input to back up.
// ----------------------------------------------------------------------------
module remote_hid_report_decoder_tb;

  import rhd_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned TargetBytes   = 1350;
  localparam int unsigned QuietFrom     = 1150;
  localparam int unsigned HoldFrom      = 500;
  localparam int unsigned HoldCycles    = 300;

  // m_axis_tdata layout, lowest field last
  typedef struct packed {
    logic [4:0]  pad;
    logic [47:0] accel;
    logic [47:0] poi;
    logic [15:0] fixed_word;
    logic [15:0] counter;
    logic [31:0] wheel_total;
    logic [7:0]  delta;
    logic [5:0]  index;
    logic [15:0] code;
    logic [4:0]  len;
    logic [7:0]  id;
  } report_t;

  typedef struct {
    logic [7:0] b;
    logic       l;
    bit         typed;
    logic [7:0] tid;
    logic [4:0] tlen;
  } dir_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // typed expectation travels alongside the request it belongs to
  bit         tag_typed = 1'b0;
  logic [7:0] tag_id    = '0;
  logic [4:0] tag_len   = '0;

  // decoder model state
  bit          in_rep   = 1'b0;
  logic [7:0]  cur_id   = '0;
  logic [4:0]  nbytes   = '0;
  logic [7:0]  store [DECODED_PAYLOAD_BYTES];
  logic [31:0] wheel    = '0;

  report_t pending [$];
  int unsigned bytes_taken = 0;
  int unsigned n_reports   = 0;
  int unsigned n_decoded   = 0;
  int unsigned n_checked   = 0;
  int unsigned errors      = 0;
  int unsigned idle_cnt    = 0;
  bit          quiet       = 1'b0;
  bit          held        = 1'b0;
  bit          gaps_on     = 1'b1;

  dir_row_t dir_tab [25] = '{
    '{8'hFF, 1'b1, 1'b0, 8'h00, 5'd0},
    '{IdDecoded, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'h00, 1'b1, 1'b1, IdDecoded, 5'd0},
    '{IdLongB, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'hAA, 1'b1, 1'b1, IdLongB, 5'd0},
    '{IdLongA, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'h55, 1'b1, 1'b1, IdLongA, 5'd2},
    '{8'h00, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'h80, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'h7F, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'h01, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'hFE, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'h40, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'hBF, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'h20, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'hDF, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'h10, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'hEF, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'h08, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'hF7, 1'b0, 1'b0, 8'h00, 5'd0},
    '{8'h02, 1'b0, 1'b0, 8'h00, 5'd0},
    '{IdDecoded, 1'b0, 1'b1, 8'h00, LenShort}
  };

  remote_hid_report_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [4:0] payload_len(input logic [7:0] id);
    if (id == IdDecoded) return LenDecoded;
    if (id == IdLongA || id == IdLongB) return LenLong;
    return LenShort;
  endfunction

  function automatic report_t close_report();
    report_t r;
    bit      hit;
    r = '0;
    hit = 1'b0;
    r.id = cur_id;
    r.len = nbytes;
    if (cur_id == IdDecoded && nbytes >= LenDecoded) begin
      r.code = {store[17], store[18]};
      r.index = IdxUnknown;
      for (int k = 0; k < NumButtons; k++) begin
        if (!hit && ButtonTable[k] == r.code) begin
          r.index = 6'(k);
          hit = 1'b1;
        end
      end
      r.delta = store[19];
      wheel = wheel + {{24{store[19][7]}}, store[19]};
      r.counter = {store[2], store[1]};
      r.fixed_word = {store[4], store[3]};
      for (int k = 0; k < 3; k++) begin
        r.poi[16*k +: 16] = {store[5 + 2*k], store[6 + 2*k]};
        r.accel[16*k +: 16] = {store[11 + 2*k], store[12 + 2*k]};
      end
      n_decoded++;
    end
    r.wheel_total = wheel;
    n_reports++;
    in_rep = 1'b0;
    nbytes = '0;
    return r;
  endfunction

  // one request into the model; returns 1 when it closes a report
  function automatic bit decode_byte(input logic [7:0] b, input logic l, output report_t r);
    r = '0;
    if (l) begin
      if (!in_rep) return 1'b0;
      r = close_report();
      return 1'b1;
    end
    if (!in_rep) begin
      cur_id = b;
      nbytes = '0;
      in_rep = 1'b1;
      return 1'b0;
    end
    if (nbytes < DECODED_PAYLOAD_BYTES) store[nbytes] = b;
    nbytes = nbytes + 5'd1;
    if (nbytes >= payload_len(cur_id)) begin
      r = close_report();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic cmp(input string name, input logic [63:0] e, input logic [63:0] g);
    if (e !== g) begin
      $error("%s: expected %0h, actual %0h", name, e, g);
      errors++;
    end
  endtask

  // request and result bookkeeping in one place, so ordering within a step is moot
  always @(posedge clk_i) begin
    report_t exp_r;
    report_t got_r;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (decode_byte(s_axis_tdata, s_axis_tlast, exp_r)) begin
        if (tag_typed) begin
          exp_r = '0;
          exp_r.id = tag_id;
          exp_r.len = tag_len;
        end
        pending.push_back(exp_r);
      end
      bytes_taken++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r = report_t'(m_axis_tdata);
      if (pending.size() == 0) begin
        $error("unexpected result, hdr_id %0h", got_r.id);
        errors++;
      end else begin
        exp_r = pending.pop_front();
        cmp("hdr_id", 64'(exp_r.id), 64'(got_r.id));
        cmp("payload_length", 64'(exp_r.len), 64'(got_r.len));
        cmp("button_code", 64'(exp_r.code), 64'(got_r.code));
        cmp("button_index", 64'(exp_r.index), 64'(got_r.index));
        cmp("wheel_delta", 64'(exp_r.delta), 64'(got_r.delta));
        cmp("wheel_total", 64'(exp_r.wheel_total), 64'(got_r.wheel_total));
        cmp("frame_counter", 64'(exp_r.counter), 64'(got_r.counter));
        cmp("fixed_word", 64'(exp_r.fixed_word), 64'(got_r.fixed_word));
        cmp("poi_words", 64'(exp_r.poi), 64'(got_r.poi));
        cmp("accel_words", 64'(exp_r.accel), 64'(got_r.accel));
        cmp("pad", 64'(exp_r.pad), 64'(got_r.pad));
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
      if (idle_cnt >= WatchdogLimit) begin
        $display("timeout: no request moved for %0d cycles", WatchdogLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!held && bytes_taken >= HoldFrom) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        held = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  task automatic put(input logic [7:0] b, input logic l);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic send_report();
    logic [7:0]  id;
    logic [4:0]  full;
    logic [15:0] code;
    int unsigned n;
    bit          cut;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: id = IdDecoded;
      4:          id = IdLongA;
      5:          id = IdLongB;
      default:    id = 8'($urandom_range(0, 255));
    endcase
    full = payload_len(id);
    cut = ($urandom_range(0, 6) == 0);
    n = cut ? $urandom_range(0, 32'(full) - 32'd1) : 32'(full);
    code = ($urandom_range(0, 9) < 7) ? ButtonTable[$urandom_range(0, NumButtons - 1)]
                                      : 16'($urandom_range(0, 65535));
    gaps_on = ($urandom_range(0, 3) != 0);
    put(id, 1'b0);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 17) begin
        put(code[15:8], 1'b0);
      end else if (i == 18) begin
        put(code[7:0], 1'b0);
      end else if (i == 19 && $urandom_range(0, 3) == 0) begin
        put($urandom_range(0, 1) ? 8'h80 : 8'h7F, 1'b0);
      end else begin
        put(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    if (cut) put(8'($urandom_range(0, 255)), 1'b1);
    // stray stream end while idle
    if ($urandom_range(0, 11) == 0) put(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      tag_typed <= dir_tab[i].typed;
      tag_id <= dir_tab[i].tid;
      tag_len <= dir_tab[i].tlen;
      put(dir_tab[i].b, dir_tab[i].l);
    end
    tag_typed <= 1'b0;

    while (bytes_taken < TargetBytes) begin
      if (bytes_taken >= QuietFrom) quiet = 1'b1;
      send_report();
    end
    s_axis_tvalid <= 1'b0;

    while (pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d input bytes, %0d reports closed, %0d fully decoded",
             bytes_taken, n_reports, n_decoded);
    $display("%0d results checked field by field, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/rhd_pkg.sv
rtl/core/rhd_front.sv
rtl/core/rhd_queue.sv
rtl/core/rhd_back.sv
rtl/core/remote_hid_report_decoder.sv
rtl/core/rhd_checker.sv
tb/remote_hid_report_decoder_tb.sv
